### design/ttfp_pkg.sv
// Package for the tracked target frame parser.
// Holds the phase encoding, frame header constants and y decoding helpers.
// No dependencies; used by the channel interfaces and the top level.
package ttfp_pkg;

    localparam int BYTE_W  = 8;
    localparam int Y_W     = 9;
    localparam int COUNT_W = 32;

    localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'd201;
    localparam logic [BYTE_W-1:0] HDR_SECOND = 8'd202;
    localparam logic [BYTE_W-1:0] HDR_THIRD  = 8'd203;
    localparam logic [Y_W-1:0]    Y_BIAS     = 9'd100;

    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    typedef enum logic [3:0] {
        PH_WAIT1 = 4'd0,
        PH_X1    = 4'd1,
        PH_Y1    = 4'd2,
        PH_WAIT2 = 4'd3,
        PH_X2    = 4'd4,
        PH_Y2    = 4'd5,
        PH_WAIT3 = 4'd6,
        PH_X3    = 4'd7,
        PH_Y3    = 4'd8
    } phase_t;

    function automatic logic signed [Y_W-1:0] decode_y(input logic [BYTE_W-1:0] b);
        decode_y = $signed({1'b0, b} - Y_BIAS);
    endfunction

    function automatic logic visible(input logic [BYTE_W-1:0] x,
                                     input logic signed [Y_W-1:0] y);
        visible = !((x == '0) && (y == $signed(-Y_BIAS)));
    endfunction

endpackage

### design/ttfp_in_if.sv
// Input channel of the tracked target frame parser: one stream word per handshake.
// Depends on ttfp_pkg for field widths.
interface ttfp_in_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [ttfp_pkg::BYTE_W-1:0]  data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

### design/ttfp_out_if.sv
// Result channel of the tracked target frame parser: one decoded word per input word.
// Depends on ttfp_pkg for field widths.
interface ttfp_out_if;
    logic                                valid;
    logic                                ready;
    logic                                frame_done;
    logic [ttfp_pkg::BYTE_W-1:0]         first_x;
    logic signed [ttfp_pkg::Y_W-1:0]     first_y;
    logic [ttfp_pkg::BYTE_W-1:0]         second_x;
    logic signed [ttfp_pkg::Y_W-1:0]     second_y;
    logic [ttfp_pkg::BYTE_W-1:0]         third_x;
    logic signed [ttfp_pkg::Y_W-1:0]     third_y;
    logic                                first_seen;
    logic                                second_seen;
    logic                                third_seen;
    logic [ttfp_pkg::COUNT_W-1:0]        frames_total;
    logic [ttfp_pkg::COUNT_W-1:0]        resyncs_total;

    modport source (output valid, input ready, output frame_done,
                    output first_x, output first_y, output second_x, output second_y,
                    output third_x, output third_y, output first_seen,
                    output second_seen, output third_seen, output frames_total,
                    output resyncs_total);
    modport sink   (input valid, output ready, input frame_done,
                    input first_x, input first_y, input second_x, input second_y,
                    input third_x, input third_y, input first_seen,
                    input second_seen, input third_seen, input frames_total,
                    input resyncs_total);
endinterface

### design/tracked_target_frame_parser_unit.sv
// Top level of the tracked target frame parser: frame state machine and counters.
// Depends on ttfp_pkg, ttfp_in_if and ttfp_out_if.
//
//   channel  dir  word
//   rx       in   kind, data_byte
//   tgt      out  frame_done, three x/y pairs, three seen flags, two counters
//
// Each word is taken into the input register, then updates the parser state and
// result register, where the result is valid; one word per clock is sustained while
// the result channel does not stall.
// rst_n clears the parser to header wait and zeroes coordinates, flags and counters.
// A stalled result holds the state; the input register still takes one more word.
module tracked_target_frame_parser_unit (
    input  logic       clk,
    input  logic       rst_n,
    ttfp_in_if.sink    rx,
    ttfp_out_if.source tgt
);

    localparam logic [ttfp_pkg::COUNT_W-1:0] COUNT_STEP = {{(ttfp_pkg::COUNT_W-1){1'b0}}, 1'b1};

    logic                              s1_valid_reg;
    logic                              s1_valid_next;
    logic                              s1_kind_reg;
    logic [ttfp_pkg::BYTE_W-1:0]       s1_byte_reg;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic                              accept;
    logic                              advance;

    ttfp_pkg::phase_t                  phase_reg;
    ttfp_pkg::phase_t                  phase_next;
    logic                              bad_hdr;

    logic                              done_reg;
    logic                              done_next;
    logic [ttfp_pkg::BYTE_W-1:0]       first_x_reg, first_x_next;
    logic [ttfp_pkg::BYTE_W-1:0]       second_x_reg, second_x_next;
    logic [ttfp_pkg::BYTE_W-1:0]       third_x_reg, third_x_next;
    logic signed [ttfp_pkg::Y_W-1:0]   first_y_reg, first_y_next;
    logic signed [ttfp_pkg::Y_W-1:0]   second_y_reg, second_y_next;
    logic signed [ttfp_pkg::Y_W-1:0]   third_y_reg, third_y_next;
    logic [2:0]                        seen_reg, seen_next;
    logic [ttfp_pkg::COUNT_W-1:0]      frames_reg, frames_next;
    logic [ttfp_pkg::COUNT_W-1:0]      resyncs_reg, resyncs_next;
    logic signed [ttfp_pkg::Y_W-1:0]   y_dec;

    assign advance  = s1_valid_reg && (!out_valid_reg || tgt.ready);
    assign rx.ready = !s1_valid_reg || advance;
    assign accept   = rx.valid && rx.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (tgt.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg <= rx.kind;
            s1_byte_reg <= rx.data_byte;
        end
    end

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        bad_hdr    = 1'b0;
        if (s1_kind_reg == ttfp_pkg::KIND_RESTART)
        begin
            phase_next = ttfp_pkg::PH_WAIT1;
        end
        else
        begin
            unique case (phase_reg)
                ttfp_pkg::PH_X1:    phase_next = ttfp_pkg::PH_Y1;
                ttfp_pkg::PH_Y1:    phase_next = ttfp_pkg::PH_WAIT2;
                ttfp_pkg::PH_X2:    phase_next = ttfp_pkg::PH_Y2;
                ttfp_pkg::PH_Y2:    phase_next = ttfp_pkg::PH_WAIT3;
                ttfp_pkg::PH_X3:    phase_next = ttfp_pkg::PH_Y3;
                ttfp_pkg::PH_Y3:    phase_next = ttfp_pkg::PH_WAIT1;
                ttfp_pkg::PH_WAIT2:
                begin
                    if (s1_byte_reg == ttfp_pkg::HDR_SECOND)
                    begin
                        phase_next = ttfp_pkg::PH_X2;
                    end
                    else
                    begin
                        bad_hdr = 1'b1;
                    end
                end
                ttfp_pkg::PH_WAIT3:
                begin
                    if (s1_byte_reg == ttfp_pkg::HDR_THIRD)
                    begin
                        phase_next = ttfp_pkg::PH_X3;
                    end
                    else
                    begin
                        bad_hdr = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = (s1_byte_reg == ttfp_pkg::HDR_FIRST)
                                 ? ttfp_pkg::PH_X1 : ttfp_pkg::PH_WAIT1;
                end
            endcase
            if (bad_hdr)
            begin
                phase_next = (s1_byte_reg == ttfp_pkg::HDR_FIRST)
                             ? ttfp_pkg::PH_X1 : ttfp_pkg::PH_WAIT1;
            end
        end
    end

    // Register updates and result.
    always_comb
    begin
        y_dec         = ttfp_pkg::decode_y(s1_byte_reg);
        done_next     = 1'b0;
        first_x_next  = first_x_reg;
        second_x_next = second_x_reg;
        third_x_next  = third_x_reg;
        first_y_next  = first_y_reg;
        second_y_next = second_y_reg;
        third_y_next  = third_y_reg;
        seen_next     = seen_reg;
        frames_next   = frames_reg;
        resyncs_next  = resyncs_reg;
        if (bad_hdr)
        begin
            resyncs_next = resyncs_reg + COUNT_STEP;
        end
        if (s1_kind_reg == ttfp_pkg::KIND_DATA)
        begin
            unique case (phase_reg)
                ttfp_pkg::PH_X1: first_x_next  = s1_byte_reg;
                ttfp_pkg::PH_Y1: first_y_next  = y_dec;
                ttfp_pkg::PH_X2: second_x_next = s1_byte_reg;
                ttfp_pkg::PH_Y2: second_y_next = y_dec;
                ttfp_pkg::PH_X3: third_x_next  = s1_byte_reg;
                ttfp_pkg::PH_Y3:
                begin
                    third_y_next = y_dec;
                    seen_next    = {ttfp_pkg::visible(third_x_reg, y_dec),
                                    ttfp_pkg::visible(second_x_reg, second_y_reg),
                                    ttfp_pkg::visible(first_x_reg, first_y_reg)};
                    frames_next  = frames_reg + COUNT_STEP;
                    done_next    = 1'b1;
                end
                default:
                begin
                    done_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= ttfp_pkg::PH_WAIT1;
            done_reg      <= 1'b0;
            first_x_reg   <= '0;
            second_x_reg  <= '0;
            third_x_reg   <= '0;
            first_y_reg   <= '0;
            second_y_reg  <= '0;
            third_y_reg   <= '0;
            seen_reg      <= '0;
            frames_reg    <= '0;
            resyncs_reg   <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                phase_reg    <= phase_next;
                done_reg     <= done_next;
                first_x_reg  <= first_x_next;
                second_x_reg <= second_x_next;
                third_x_reg  <= third_x_next;
                first_y_reg  <= first_y_next;
                second_y_reg <= second_y_next;
                third_y_reg  <= third_y_next;
                seen_reg     <= seen_next;
                frames_reg   <= frames_next;
                resyncs_reg  <= resyncs_next;
            end
        end
    end

    assign tgt.valid         = out_valid_reg;
    assign tgt.frame_done    = done_reg;
    assign tgt.first_x       = first_x_reg;
    assign tgt.first_y       = first_y_reg;
    assign tgt.second_x      = second_x_reg;
    assign tgt.second_y      = second_y_reg;
    assign tgt.third_x       = third_x_reg;
    assign tgt.third_y       = third_y_reg;
    assign tgt.first_seen    = seen_reg[0];
    assign tgt.second_seen   = seen_reg[1];
    assign tgt.third_seen    = seen_reg[2];
    assign tgt.frames_total  = frames_reg;
    assign tgt.resyncs_total = resyncs_reg;

endmodule

### tb/tb_top.sv
// Testbench for tracked_target_frame_parser_unit: a directed table, then random frames and faults.
// A built-in parser predictor checks every result word field by field; typed directed rows set some fields.
// Depends on ttfp_pkg, ttfp_in_if, ttfp_out_if and the top level.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 1400;
    localparam int DIRECTED_ROWS = 23;
    localparam int DRAIN_CYCLES = 10;

    typedef logic [ttfp_pkg::BYTE_W-1:0]  byte_t;
    typedef logic [ttfp_pkg::Y_W-1:0]     y_t;
    typedef logic [ttfp_pkg::COUNT_W-1:0] count_t;

    typedef struct packed {
        logic    kind;
        byte_t   data_byte;
        logic    typed;
        logic    done;
        logic [2:0] seen;
        count_t  frames;
        count_t  resyncs;
    } stim_row_t;

    typedef struct packed {
        logic              done;
        logic [2:0][ttfp_pkg::BYTE_W-1:0] x;
        logic [2:0][ttfp_pkg::Y_W-1:0]    y;
        logic [2:0]        seen;
        count_t            frames;
        count_t            resyncs;
    } target_report_t;

    localparam y_t HIDDEN_Y = '0 - ttfp_pkg::Y_BIAS;

    logic clk = 1'b0;
    logic rst_n;

    ttfp_in_if  rx ();
    ttfp_out_if tgt ();

    tracked_target_frame_parser_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .tgt   (tgt)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    ttfp_pkg::phase_t                 parse_phase;
    logic [2:0][ttfp_pkg::BYTE_W-1:0] held_x;
    logic [2:0][ttfp_pkg::Y_W-1:0]    held_y;
    logic [2:0]                       held_seen;
    count_t                           frame_count;
    count_t                           resync_count;

    stim_row_t      directed_rows [DIRECTED_ROWS];
    stim_row_t      stim_q [$];
    target_report_t report_q [$];
    stim_row_t      cur_word;

    int  words_total = 0;
    int  words_sent = 0;
    int  words_checked = 0;
    int  err_count = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    bit  src_calm = 1'b0;
    bit  sink_calm = 1'b0;

    string x_names [3] = '{"first_x", "second_x", "third_x"};
    string y_names [3] = '{"first_y", "second_y", "third_y"};
    string seen_names [3] = '{"first_seen", "second_seen", "third_seen"};

    function automatic y_t unbias_y(input byte_t b);
        return {1'b0, b} - ttfp_pkg::Y_BIAS;
    endfunction

    function automatic void resync_on(input byte_t b);
        resync_count++;
        parse_phase = (b == ttfp_pkg::HDR_FIRST) ? ttfp_pkg::PH_X1 : ttfp_pkg::PH_WAIT1;
    endfunction

    function automatic target_report_t advance_parser(input logic kind, input byte_t b);
        target_report_t r;
        r.done = 1'b0;
        if (kind == ttfp_pkg::KIND_RESTART)
            parse_phase = ttfp_pkg::PH_WAIT1;
        else
        begin
            case (parse_phase)
                ttfp_pkg::PH_X1:
                begin
                    held_x[0] = b;
                    parse_phase = ttfp_pkg::PH_Y1;
                end
                ttfp_pkg::PH_Y1:
                begin
                    held_y[0] = unbias_y(b);
                    parse_phase = ttfp_pkg::PH_WAIT2;
                end
                ttfp_pkg::PH_WAIT2:
                    if (b == ttfp_pkg::HDR_SECOND)
                        parse_phase = ttfp_pkg::PH_X2;
                    else
                        resync_on(b);
                ttfp_pkg::PH_X2:
                begin
                    held_x[1] = b;
                    parse_phase = ttfp_pkg::PH_Y2;
                end
                ttfp_pkg::PH_Y2:
                begin
                    held_y[1] = unbias_y(b);
                    parse_phase = ttfp_pkg::PH_WAIT3;
                end
                ttfp_pkg::PH_WAIT3:
                    if (b == ttfp_pkg::HDR_THIRD)
                        parse_phase = ttfp_pkg::PH_X3;
                    else
                        resync_on(b);
                ttfp_pkg::PH_X3:
                begin
                    held_x[2] = b;
                    parse_phase = ttfp_pkg::PH_Y3;
                end
                ttfp_pkg::PH_Y3:
                begin
                    held_y[2] = unbias_y(b);
                    for (int i = 0; i < 3; i++)
                        held_seen[i] = !(held_x[i] == '0 && held_y[i] == HIDDEN_Y);
                    frame_count++;
                    parse_phase = ttfp_pkg::PH_WAIT1;
                    r.done = 1'b1;
                end
                default:
                    parse_phase = (b == ttfp_pkg::HDR_FIRST)
                                  ? ttfp_pkg::PH_X1 : ttfp_pkg::PH_WAIT1;
            endcase
        end
        r.x = held_x;
        r.y = held_y;
        r.seen = held_seen;
        r.frames = frame_count;
        r.resyncs = resync_count;
        return r;
    endfunction

    function automatic int pick_gap(inout bit calm);
        int r;
        if ($urandom_range(0, 99) == 0)
            calm = !calm;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic void queue_word(input logic kind, input byte_t b);
        stim_row_t w;
        w = '0;
        w.kind = kind;
        w.data_byte = b;
        stim_q.push_back(w);
    endfunction

    function automatic byte_t frame_byte(input int pos);
        int r;
        r = $urandom_range(0, 9);
        case (pos)
            0: return ttfp_pkg::HDR_FIRST;
            3: return ttfp_pkg::HDR_SECOND;
            6: return ttfp_pkg::HDR_THIRD;
            1, 4, 7: return (r < 3) ? '0 : byte_t'($urandom);
            default:
            begin
                if (r < 3)
                    return '0;
                if (r == 3)
                    return byte_t'(ttfp_pkg::Y_BIAS);
                return byte_t'($urandom);
            end
        endcase
    endfunction

    task automatic note_field(input string name, input logic signed [63:0] e,
                              input logic signed [63:0] a);
        if (e !== a)
        begin
            $error("%s: expected %0d, got %0d", name, e, a);
            err_count++;
        end
    endtask

    task automatic check_word(input target_report_t e);
        target_report_t a;
        a.done = tgt.frame_done;
        a.x = {tgt.third_x, tgt.second_x, tgt.first_x};
        a.y = {tgt.third_y, tgt.second_y, tgt.first_y};
        a.seen = {tgt.third_seen, tgt.second_seen, tgt.first_seen};
        a.frames = tgt.frames_total;
        a.resyncs = tgt.resyncs_total;
        note_field("frame_done", e.done, a.done);
        for (int i = 0; i < 3; i++)
        begin
            note_field(x_names[i], e.x[i], a.x[i]);
            note_field(y_names[i], $signed(e.y[i]), $signed(a.y[i]));
            note_field(seen_names[i], e.seen[i], a.seen[i]);
        end
        note_field("frames_total", e.frames, a.frames);
        note_field("resyncs_total", e.resyncs, a.resyncs);
    endtask

    task automatic record_word(input stim_row_t w);
        target_report_t r;
        r = advance_parser(w.kind, w.data_byte);
        if (w.typed)
        begin
            r.done = w.done;
            r.seen = w.seen;
            r.frames = w.frames;
            r.resyncs = w.resyncs;
        end
        report_q.push_back(r);
        words_sent++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rx.valid && rx.ready)
                record_word(cur_word);
            if (rx.valid && !rx.ready)
                ;
            else if (gap_left > 0)
            begin
                rx.valid <= 1'b0;
                gap_left--;
            end
            else if (stim_q.size() > 0)
            begin
                cur_word = stim_q.pop_front();
                rx.valid <= 1'b1;
                rx.kind <= cur_word.kind;
                rx.data_byte <= cur_word.data_byte;
                gap_left = pick_gap(src_calm);
            end
            else
                rx.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (tgt.valid && tgt.ready)
            begin
                if (report_q.size() == 0)
                begin
                    $error("result word with nothing expected");
                    err_count++;
                end
                else
                begin
                    check_word(report_q.pop_front());
                    words_checked++;
                end
            end
            if (stall_left > 0)
            begin
                tgt.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                tgt.ready <= 1'b1;
                stall_left = pick_gap(sink_calm);
            end
        end
    end

    initial
    begin
        int pick;
        int cut;
        byte_t bad;

        rst_n = 1'b0;
        rx.valid = 1'b0;
        rx.kind = ttfp_pkg::KIND_DATA;
        rx.data_byte = '0;
        tgt.ready = 1'b0;
        parse_phase = ttfp_pkg::PH_WAIT1;
        held_x = '0;
        held_y = '0;
        held_seen = '0;
        frame_count = '0;
        resync_count = '0;

        directed_rows = '{
            '{ttfp_pkg::KIND_DATA,    8'd0,                1'b1, 1'b0, 3'b000, 32'd0, 32'd0},
            '{ttfp_pkg::KIND_RESTART, ttfp_pkg::HDR_FIRST, 1'b1, 1'b0, 3'b000, 32'd0, 32'd0},
            '{ttfp_pkg::KIND_DATA,    ttfp_pkg::HDR_FIRST, 1'b0, 1'b0, 3'b000, 32'd0, 32'd0},
            '{ttfp_pkg::KIND_DATA,    8'd0,                1'b0, 1'b0, 3'b000, 32'd0, 32'd0},
            '{ttfp_pkg::KIND_DATA,    8'd0,                1'b0, 1'b0, 3'b000, 32'd0, 32'd0},
            '{ttfp_pkg::KIND_DATA,    ttfp_pkg::HDR_SECOND, 1'b0, 1'b0, 3'b000, 32'd0, 32'd0},
            '{ttfp_pkg::KIND_DATA,    8'd255,              1'b0, 1'b0, 3'b000, 32'd0, 32'd0},
            '{ttfp_pkg::KIND_DATA,    8'd255,              1'b0, 1'b0, 3'b000, 32'd0, 32'd0},
            '{ttfp_pkg::KIND_DATA,    ttfp_pkg::HDR_THIRD, 1'b0, 1'b0, 3'b000, 32'd0, 32'd0},
            '{ttfp_pkg::KIND_DATA,    8'd0,                1'b0, 1'b0, 3'b000, 32'd0, 32'd0},
            '{ttfp_pkg::KIND_DATA,    8'd100,              1'b1, 1'b1, 3'b110, 32'd1, 32'd0},
            '{ttfp_pkg::KIND_DATA,    ttfp_pkg::HDR_FIRST, 1'b0, 1'b0, 3'b000, 32'd0, 32'd0},
            '{ttfp_pkg::KIND_DATA,    8'd7,                1'b0, 1'b0, 3'b000, 32'd0, 32'd0},
            '{ttfp_pkg::KIND_DATA,    8'd50,               1'b0, 1'b0, 3'b000, 32'd0, 32'd0},
            '{ttfp_pkg::KIND_DATA,    ttfp_pkg::HDR_FIRST, 1'b1, 1'b0, 3'b110, 32'd1, 32'd1},
            '{ttfp_pkg::KIND_DATA,    8'd128,              1'b0, 1'b0, 3'b000, 32'd0, 32'd0},
            '{ttfp_pkg::KIND_DATA,    8'd1,                1'b0, 1'b0, 3'b000, 32'd0, 32'd0},
            '{ttfp_pkg::KIND_DATA,    ttfp_pkg::HDR_SECOND, 1'b0, 1'b0, 3'b000, 32'd0, 32'd0},
            '{ttfp_pkg::KIND_DATA,    8'd0,                1'b0, 1'b0, 3'b000, 32'd0, 32'd0},
            '{ttfp_pkg::KIND_DATA,    8'd0,                1'b0, 1'b0, 3'b000, 32'd0, 32'd0},
            '{ttfp_pkg::KIND_DATA,    8'd99,               1'b1, 1'b0, 3'b110, 32'd1, 32'd2},
            '{ttfp_pkg::KIND_DATA,    ttfp_pkg::HDR_FIRST, 1'b0, 1'b0, 3'b000, 32'd0, 32'd0},
            '{ttfp_pkg::KIND_RESTART, 8'd0,                1'b1, 1'b0, 3'b110, 32'd1, 32'd2}
        };
        for (int i = 0; i < DIRECTED_ROWS; i++)
            stim_q.push_back(directed_rows[i]);

        while (stim_q.size() < DIRECTED_ROWS + RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                for (int p = 0; p < 9; p++)
                    queue_word(ttfp_pkg::KIND_DATA, frame_byte(p));
            end
            else if (pick < 80)
            begin
                cut = $urandom_range(0, 1) ? 3 : 6;
                for (int p = 0; p < cut; p++)
                    queue_word(ttfp_pkg::KIND_DATA, frame_byte(p));
                bad = ($urandom_range(0, 2) == 0) ? ttfp_pkg::HDR_FIRST : byte_t'($urandom);
                if (bad == ((cut == 3) ? ttfp_pkg::HDR_SECOND : ttfp_pkg::HDR_THIRD))
                    bad = bad ^ 8'd1;
                queue_word(ttfp_pkg::KIND_DATA, bad);
            end
            else if (pick < 90)
            begin
                cut = $urandom_range(0, 8);
                for (int p = 0; p < cut; p++)
                    queue_word(ttfp_pkg::KIND_DATA, frame_byte(p));
                queue_word(ttfp_pkg::KIND_RESTART, byte_t'($urandom));
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    queue_word(ttfp_pkg::KIND_DATA, byte_t'($urandom));
            end
        end
        words_total = stim_q.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (!(words_sent == words_total && report_q.size() == 0))
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb_top: %0d words checked (%0d directed, rest random framed traffic)",
                 words_checked, DIRECTED_ROWS);
        $display("tb_top: %0d frames decoded, %0d header resyncs", frame_count, resync_count);
        if (err_count == 0 && report_q.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("tb_top: timeout");
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

### filelist.f
design/ttfp_pkg.sv
design/ttfp_in_if.sv
design/ttfp_out_if.sv
design/tracked_target_frame_parser_unit.sv
tb/tb_top.sv
